/* rtl/core/rpaa_pkg.sv */
// Package of the redundant pair activity arbiter: request, mode and step codes,
// register indexes, request payload structs and default values.
// No dependencies.
package rpaa_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    REQ_TICK         = 3'd0,
    REQ_ENABLE       = 3'd1,
    REQ_DISABLE      = 3'd2,
    REQ_ORDER_PRIM   = 3'd3,
    REQ_ORDER_RESV   = 3'd4,
    REQ_ORDER_NONE   = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    M_START      = 3'd0,
    M_PASSIVE    = 3'd1,
    M_TO_ACTIVE  = 3'd2,
    M_ACTIVE     = 3'd3,
    M_TO_PASSIVE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    TP_WAIT_CTRL = 2'd0,
    TP_RELEASE   = 2'd1,
    TP_OPERATE   = 2'd2
  } tp_step_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IS_PRIMARY     = 3'd0,
    CFG_START_PRIMARY  = 3'd1,
    CFG_START_RESERVE  = 3'd2,
    CFG_RELAY_OPERATE  = 3'd3,
    CFG_RELAY_RELEASE  = 3'd4,
    CFG_REMAIN_PASSIVE = 3'd5,
    CFG_SAFE_CHANGE    = 3'd6
  } cfg_idx_e;

  localparam logic [CFG_DATA_W-1:0] START_PRIMARY_RST  = 16'd100;
  localparam logic [CFG_DATA_W-1:0] START_RESERVE_RST  = 16'd600;
  localparam logic [CFG_DATA_W-1:0] RELAY_OPERATE_RST  = 16'd50;
  localparam logic [CFG_DATA_W-1:0] RELAY_RELEASE_RST  = 16'd50;
  localparam logic [CFG_DATA_W-1:0] REMAIN_PASSIVE_RST = 16'd200;
  localparam logic [CFG_DATA_W-1:0] SAFE_CHANGE_RST    = 16'd100;

  typedef struct packed {
    logic [2:0] req_type;
    logic       own_working;
    logic       relay_contacts_mine;
    logic       own_control_active;
    logic       own_host_link;
    logic       neighbor_link;
    logic       neighbor_working;
    logic       neighbor_active;
    logic       neighbor_host_link;
    logic       neighbor_hears_me;
    logic       neighbor_in_work;
    logic [1:0] relay_health;
  } in_item_t;

  typedef struct packed {
    logic       is_active;
    logic       relay_drive;
    logic       request_disable_control;
    logic       init_done;
    logic [2:0] mode;
  } out_item_t;

endpackage

/* rtl/core/rpaa_in_if.sv */
// Request channel of the redundant pair activity arbiter.
// Depends on rpaa_pkg for the request payload struct.
interface rpaa_in_if import rpaa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rpaa_out_if.sv */
// Result channel of the redundant pair activity arbiter.
// Depends on rpaa_pkg for the result payload struct.
interface rpaa_out_if import rpaa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/redundant_pair_activity_arbiter.sv */
// Top level of the redundant pair activity arbiter: request register, decision logic,
// state and configuration registers, and the result register.
// Depends on rpaa_pkg, rpaa_in_if and rpaa_out_if.

// Every request (tick, enable, disable or change order) yields exactly one result that
// reports the flags and mode after it. One request is taken per clock cycle unless the
// request register is full and the result register holds a result that is not taken. A
// request passes through the request register into the result register. The result
// register holds a result until it is taken, and an empty request register still takes
// the next request while that result waits. Configuration must be written through the
// plain write port only while no request is in flight; the block does not enforce this.
module redundant_pair_activity_arbiter
  import rpaa_pkg::*;
#(
  parameter int TimerBits = TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rpaa_in_if.sink               in_i,
  rpaa_out_if.source            out_o
);

  localparam int TW = TimerBits;

  logic                  is_primary_q;
  logic [CFG_DATA_W-1:0] start_primary_q, start_reserve_q;
  logic [CFG_DATA_W-1:0] relay_operate_q, relay_release_q;
  logic [CFG_DATA_W-1:0] remain_passive_q, safe_change_q;

  logic      s1_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      s1_adv;

  mode_e          mode_q, mode_d;
  logic           tas_q, tas_d;
  tp_step_e       tps_q, tps_d;
  logic [TW-1:0]  tc_q, tc_d;
  logic [TW-1:0]  sc_q, sc_d;
  logic           used_q, used_d;
  logic           pend_q, pend_d;
  logic           en_q, en_d;
  logic           act_q, act_d;
  logic           relay_q, relay_d;
  logic           reqdis_q, reqdis_d;
  logic           init_q, init_d;

  assign s1_adv = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_primary_q     <= 1'b1;
      start_primary_q  <= START_PRIMARY_RST;
      start_reserve_q  <= START_RESERVE_RST;
      relay_operate_q  <= RELAY_OPERATE_RST;
      relay_release_q  <= RELAY_RELEASE_RST;
      remain_passive_q <= REMAIN_PASSIVE_RST;
      safe_change_q    <= SAFE_CHANGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IS_PRIMARY:     is_primary_q     <= cfg_data_i[0];
        CFG_START_PRIMARY:  start_primary_q  <= cfg_data_i;
        CFG_START_RESERVE:  start_reserve_q  <= cfg_data_i;
        CFG_RELAY_OPERATE:  relay_operate_q  <= cfg_data_i;
        CFG_RELAY_RELEASE:  relay_release_q  <= cfg_data_i;
        CFG_REMAIN_PASSIVE: remain_passive_q <= cfg_data_i;
        CFG_SAFE_CHANGE:    safe_change_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (s1_adv) begin
      out_q.is_active               <= act_d;
      out_q.relay_drive             <= relay_d;
      out_q.request_disable_control <= reqdis_d;
      out_q.init_done               <= init_d;
      out_q.mode                    <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_START;
      tas_q    <= 1'b0;
      tps_q    <= TP_WAIT_CTRL;
      tc_q     <= '0;
      sc_q     <= '0;
      used_q   <= 1'b0;
      pend_q   <= 1'b0;
      en_q     <= 1'b0;
      act_q    <= 1'b0;
      relay_q  <= 1'b0;
      reqdis_q <= 1'b0;
      init_q   <= 1'b0;
    end else if (s1_adv) begin
      mode_q   <= mode_d;
      tas_q    <= tas_d;
      tps_q    <= tps_d;
      tc_q     <= tc_d;
      sc_q     <= sc_d;
      used_q   <= used_d;
      pend_q   <= pend_d;
      en_q     <= en_d;
      act_q    <= act_d;
      relay_q  <= relay_d;
      reqdis_q <= reqdis_d;
      init_q   <= init_d;
    end
  end

  // One step of the safe-state change timer; true when it runs out.
  function automatic logic safe_step(inout logic [TW-1:0] cnt, inout logic used,
                                     input logic [TW-1:0] rld);
    logic fire;
    fire = 1'b0;
    used = 1'b1;
    if (cnt == '0) begin
      cnt = rld;
    end else begin
      cnt = cnt - TW'(1);
      fire = (cnt == '0);
    end
    return fire;
  endfunction

  always_comb begin
    logic          ow, ct, oca, ohl, nl, nw, na, nhl, nhr, nin, prim, done;
    logic [TW-1:0] rld_safe, remain;
    mode_d   = mode_q;
    tas_d    = tas_q;
    tps_d    = tps_q;
    tc_d     = tc_q;
    sc_d     = sc_q;
    used_d   = used_q;
    pend_d   = pend_q;
    en_d     = en_q;
    act_d    = act_q;
    relay_d  = relay_q;
    reqdis_d = reqdis_q;
    init_d   = init_q;
    ow   = in_q.own_working;
    ct   = in_q.relay_contacts_mine;
    oca  = in_q.own_control_active;
    ohl  = in_q.own_host_link;
    nl   = in_q.neighbor_link;
    nw   = in_q.neighbor_working;
    na   = in_q.neighbor_active;
    nhl  = in_q.neighbor_host_link;
    nhr  = in_q.neighbor_hears_me;
    nin  = in_q.neighbor_in_work;
    prim = is_primary_q;
    done = 1'b0;
    rld_safe = TW'(safe_change_q);
    remain   = TW'(remain_passive_q);

    unique case (in_q.req_type)
      REQ_TICK: begin
        if (en_q) begin
          if (tc_d != '0) begin
            tc_d = tc_d - TW'(1);
          end
          if (!used_d) begin
            sc_d = '0;
          end
          used_d = 1'b0;
          unique case (mode_q)
            M_START: begin
              if (tc_d == '0) begin
                init_d = 1'b1;
                mode_d = (!nl && prim) ? M_TO_ACTIVE : M_PASSIVE;
              end
            end
            M_PASSIVE: begin
              mode_d = M_PASSIVE;
              if (tc_d == '0) begin
                if (!ow) begin
                  if (!nl) begin
                    mode_d = M_TO_ACTIVE;
                  end else if (nw) begin
                    mode_d = M_PASSIVE;
                  end else if (!ohl) begin
                    if (!nhl && !na) begin
                      if (safe_step(sc_d, used_d, rld_safe)) mode_d = M_TO_ACTIVE;
                    end
                  end else begin
                    if (!nhl) begin
                      if (safe_step(sc_d, used_d, rld_safe)) begin
                        mode_d = M_TO_ACTIVE;
                        done = 1'b1;
                      end
                    end
                    if (!done && !na) begin
                      if (safe_step(sc_d, used_d, rld_safe)) mode_d = M_TO_ACTIVE;
                    end
                  end
                end else if (!nl || !nw || !na) begin
                  mode_d = M_TO_ACTIVE;
                end
              end
            end
            M_TO_ACTIVE: begin
              if (in_q.relay_health != 2'd0) begin
                act_d = 1'b1;
                mode_d = M_ACTIVE;
              end else if (!tas_q) begin
                if (!prim) begin
                  if (!ct) begin
                    mode_d = M_PASSIVE;
                  end else begin
                    act_d = 1'b1;
                    mode_d = M_ACTIVE;
                  end
                end else begin
                  relay_d = 1'b1;
                  tc_d = TW'(relay_operate_q);
                  tas_d = 1'b1;
                end
              end else if (tc_d == '0) begin
                tas_d = 1'b0;
                relay_d = 1'b0;
                tc_d = TW'(relay_release_q);
                mode_d = M_PASSIVE;
              end else if (ct) begin
                tas_d = 1'b0;
                act_d = 1'b1;
                mode_d = M_ACTIVE;
              end
            end
            M_ACTIVE: begin
              mode_d = M_ACTIVE;
              if (tc_d != '0) begin
                done = 1'b1;
              end
              if (!done && !ow) begin
                if (!ohl) begin
                  if (!nl) begin
                    mode_d = ct ? M_ACTIVE : M_TO_PASSIVE;
                    done = 1'b1;
                  end else begin
                    if (!nw) begin
                      if (!nhl) begin
                        if (!na || prim) begin
                          done = 1'b1;
                        end else if (safe_step(sc_d, used_d, rld_safe)) begin
                          tc_d = remain;
                          mode_d = M_TO_PASSIVE;
                          done = 1'b1;
                        end
                      end
                      if (!done && safe_step(sc_d, used_d, rld_safe)) begin
                        tc_d = remain;
                        mode_d = M_TO_PASSIVE;
                        done = 1'b1;
                      end
                    end
                    if (!done && safe_step(sc_d, used_d, rld_safe)) begin
                      tc_d = remain;
                      mode_d = M_TO_PASSIVE;
                      done = 1'b1;
                    end
                  end
                end
                if (!done) begin
                  if (!nl) begin
                    mode_d = ct ? M_ACTIVE : M_TO_PASSIVE;
                    done = 1'b1;
                  end else if (!nw) begin
                    if (!nhl) begin
                      done = 1'b1;
                    end else begin
                      if (!nhr) begin
                        if (!na) begin
                          done = 1'b1;
                        end else if (safe_step(sc_d, used_d, rld_safe)) begin
                          tc_d = remain;
                          mode_d = M_TO_PASSIVE;
                          done = 1'b1;
                        end
                      end
                      if (!done) begin
                        if (!na || prim) begin
                          done = 1'b1;
                        end else if (safe_step(sc_d, used_d, rld_safe)) begin
                          tc_d = remain;
                          mode_d = M_TO_PASSIVE;
                          done = 1'b1;
                        end
                      end
                    end
                  end
                  if (!done && safe_step(sc_d, used_d, rld_safe)) begin
                    tc_d = remain;
                    mode_d = M_TO_PASSIVE;
                    done = 1'b1;
                  end
                end
              end
              if (!done) begin
                if (!ct) begin
                  mode_d = M_TO_PASSIVE;
                end else if (!nl) begin
                  mode_d = M_ACTIVE;
                end else if (!nhr) begin
                  mode_d = nw ? M_TO_PASSIVE : M_ACTIVE;
                end else if (!oca && pend_q && nw && nin) begin
                  mode_d = M_TO_PASSIVE;
                end else begin
                  mode_d = M_ACTIVE;
                end
              end
            end
            M_TO_PASSIVE: begin
              unique case (tps_q)
                TP_WAIT_CTRL: begin
                  if (oca) begin
                    reqdis_d = 1'b1;
                  end else begin
                    reqdis_d = 1'b0;
                    relay_d = 1'b0;
                    if (!prim) begin
                      act_d = 1'b0;
                      tc_d = remain;
                      mode_d = M_PASSIVE;
                    end else begin
                      tc_d = TW'(relay_release_q);
                      tps_d = TP_RELEASE;
                    end
                  end
                end
                TP_RELEASE: begin
                  if (tc_d == '0) begin
                    relay_d = 1'b1;
                    tc_d = TW'(relay_operate_q);
                    tps_d = TP_OPERATE;
                  end else if (!ct) begin
                    act_d = 1'b0;
                    tc_d = remain;
                    tps_d = TP_WAIT_CTRL;
                    mode_d = M_PASSIVE;
                  end
                end
                TP_OPERATE: begin
                  if (tc_d == '0) begin
                    tps_d = TP_WAIT_CTRL;
                    mode_d = M_ACTIVE;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      REQ_ENABLE: begin
        act_d    = 1'b0;
        relay_d  = 1'b0;
        reqdis_d = 1'b0;
        mode_d   = M_START;
        tas_d    = 1'b0;
        tps_d    = TP_WAIT_CTRL;
        tc_d     = prim ? TW'(start_primary_q) : TW'(start_reserve_q);
        sc_d     = '0;
        used_d   = 1'b0;
        en_d     = 1'b1;
      end
      REQ_DISABLE: begin
        en_d = 1'b0;
      end
      REQ_ORDER_PRIM, REQ_ORDER_RESV, REQ_ORDER_NONE: begin
        pend_d = act_q && ((in_q.req_type == REQ_ORDER_PRIM && !prim) ||
                           (in_q.req_type == REQ_ORDER_RESV && prim));
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_tick_disabled_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && in_q.req_type == REQ_TICK && !en_q |=> $stable(mode_q) && $stable(tc_q))
    else $error("Tick while disabled changed the mode or the countdown.");

  a_enable_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && in_q.req_type == REQ_ENABLE |=> mode_q == M_START && en_q && !act_q)
    else $error("Enable did not restart the mode machine.");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q && out_q.mode == mode_q)
    else $error("Processed request left no matching result.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("Request channel stalled with an empty result register.");
`endif

endmodule

/* tb/tb_redundant_pair_activity_arbiter.sv */
`timescale 1ns / 1ps
// Testbench of the redundant pair activity arbiter: sends all request codes with random
// idling, and checks every result against a built-in model of the mode logic.
// Depends on rpaa_pkg, rpaa_in_if, rpaa_out_if and redundant_pair_activity_arbiter.
module tb_redundant_pair_activity_arbiter;
  import rpaa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int NUM_REGS = int'(CFG_SAFE_CHANGE) + 1;
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam logic [1:0] RH_NORMAL = 2'd0;
  localparam logic [1:0] RH_NOT_ON = 2'd1;
  localparam logic [1:0] RH_FAULT  = 2'd2;
  localparam logic [1:0] RH_SPARE  = 2'd3;
  localparam logic [CFG_DATA_W-1:0] TIMER_MAX = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rpaa_in_if  req_if ();
  rpaa_out_if res_if ();

  redundant_pair_activity_arbiter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if.sink),
    .out_o      (res_if.source)
  );

  // Shadow registers and state of the arbiter model.
  logic                  cfg_primary;
  logic [CFG_DATA_W-1:0] cfg_start_p, cfg_start_r, cfg_operate, cfg_release;
  logic [CFG_DATA_W-1:0] cfg_remain, cfg_safe;
  logic [CFG_DATA_W-1:0] reg_plan [NUM_REGS];

  mode_e                 st_mode;
  logic                  ta_step;
  tp_step_e              tp_step;
  logic [CFG_DATA_W-1:0] trans_cnt, safe_cnt;
  logic                  safe_used, order_pending, enabled;
  logic                  f_act, f_relay, f_reqdis, f_init;
  in_item_t              tk;

  in_item_t  field_state;
  out_item_t predicted_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void init_model();
    cfg_primary = 1'b1;
    cfg_start_p = START_PRIMARY_RST;
    cfg_start_r = START_RESERVE_RST;
    cfg_operate = RELAY_OPERATE_RST;
    cfg_release = RELAY_RELEASE_RST;
    cfg_remain  = REMAIN_PASSIVE_RST;
    cfg_safe    = SAFE_CHANGE_RST;
    st_mode = M_START;
    ta_step = 1'b0;
    tp_step = TP_WAIT_CTRL;
    trans_cnt = '0;
    safe_cnt = '0;
    safe_used = 1'b0;
    order_pending = 1'b0;
    enabled = 1'b0;
    {f_act, f_relay, f_reqdis, f_init} = '0;
  endfunction

  function automatic logic safe_timer_tick();
    safe_used = 1'b1;
    if (safe_cnt == '0) begin
      safe_cnt = cfg_safe;
      return 1'b0;
    end
    safe_cnt = safe_cnt - CFG_DATA_W'(1);
    return safe_cnt == '0;
  endfunction

  function automatic logic relinquish();
    if (safe_timer_tick()) begin
      trans_cnt = cfg_remain;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mode_e passive_next();
    if (trans_cnt != '0) return M_PASSIVE;
    if (!tk.own_working) begin
      if (!tk.neighbor_link) return M_TO_ACTIVE;
      if (tk.neighbor_working) return M_PASSIVE;
      if (!tk.own_host_link) begin
        if (!tk.neighbor_host_link && !tk.neighbor_active) begin
          if (safe_timer_tick()) return M_TO_ACTIVE;
        end
        return M_PASSIVE;
      end
      if (!tk.neighbor_host_link) begin
        if (safe_timer_tick()) return M_TO_ACTIVE;
      end
      if (!tk.neighbor_active) begin
        if (safe_timer_tick()) return M_TO_ACTIVE;
      end
      return M_PASSIVE;
    end
    if (!tk.neighbor_link || !tk.neighbor_working || !tk.neighbor_active) return M_TO_ACTIVE;
    return M_PASSIVE;
  endfunction

  function automatic mode_e to_active_next();
    if (tk.relay_health != RH_NORMAL) begin
      f_act = 1'b1;
      return M_ACTIVE;
    end
    if (!ta_step) begin
      if (!cfg_primary) begin
        if (!tk.relay_contacts_mine) return M_PASSIVE;
        f_act = 1'b1;
        return M_ACTIVE;
      end
      f_relay = 1'b1;
      trans_cnt = cfg_operate;
      ta_step = 1'b1;
      return M_TO_ACTIVE;
    end
    if (trans_cnt == '0) begin
      ta_step = 1'b0;
      f_relay = 1'b0;
      trans_cnt = cfg_release;
      return M_PASSIVE;
    end
    if (!tk.relay_contacts_mine) return M_TO_ACTIVE;
    ta_step = 1'b0;
    f_act = 1'b1;
    return M_ACTIVE;
  endfunction

  function automatic mode_e active_next();
    if (trans_cnt != '0) return M_ACTIVE;
    if (!tk.own_working) begin
      if (!tk.own_host_link) begin
        if (!tk.neighbor_link) return tk.relay_contacts_mine ? M_ACTIVE : M_TO_PASSIVE;
        if (!tk.neighbor_working) begin
          if (!tk.neighbor_host_link) begin
            if (!tk.neighbor_active || cfg_primary) return M_ACTIVE;
            if (relinquish()) return M_TO_PASSIVE;
          end
          if (relinquish()) return M_TO_PASSIVE;
        end
        if (relinquish()) return M_TO_PASSIVE;
      end
      if (!tk.neighbor_link) return tk.relay_contacts_mine ? M_ACTIVE : M_TO_PASSIVE;
      if (!tk.neighbor_working) begin
        if (!tk.neighbor_host_link) return M_ACTIVE;
        if (!tk.neighbor_hears_me) begin
          if (!tk.neighbor_active) return M_ACTIVE;
          if (relinquish()) return M_TO_PASSIVE;
        end
        if (!tk.neighbor_active || cfg_primary) return M_ACTIVE;
        if (relinquish()) return M_TO_PASSIVE;
      end
      if (relinquish()) return M_TO_PASSIVE;
    end
    if (!tk.relay_contacts_mine) return M_TO_PASSIVE;
    if (!tk.neighbor_link) return M_ACTIVE;
    if (!tk.neighbor_hears_me) return tk.neighbor_working ? M_TO_PASSIVE : M_ACTIVE;
    if (!tk.own_control_active && order_pending && tk.neighbor_working &&
        tk.neighbor_in_work) return M_TO_PASSIVE;
    return M_ACTIVE;
  endfunction

  function automatic mode_e to_passive_next();
    case (tp_step)
      TP_WAIT_CTRL: begin
        if (tk.own_control_active) begin
          f_reqdis = 1'b1;
          return M_TO_PASSIVE;
        end
        f_reqdis = 1'b0;
        f_relay = 1'b0;
        if (!cfg_primary) begin
          f_act = 1'b0;
          trans_cnt = cfg_remain;
          return M_PASSIVE;
        end
        trans_cnt = cfg_release;
        tp_step = TP_RELEASE;
        return M_TO_PASSIVE;
      end
      TP_RELEASE: begin
        if (trans_cnt == '0) begin
          f_relay = 1'b1;
          trans_cnt = cfg_operate;
          tp_step = TP_OPERATE;
          return M_TO_PASSIVE;
        end
        if (!tk.relay_contacts_mine) begin
          f_act = 1'b0;
          trans_cnt = cfg_remain;
          tp_step = TP_WAIT_CTRL;
          return M_PASSIVE;
        end
        return M_TO_PASSIVE;
      end
      TP_OPERATE: begin
        if (trans_cnt != '0) return M_TO_PASSIVE;
        tp_step = TP_WAIT_CTRL;
        return M_ACTIVE;
      end
      default: return M_TO_PASSIVE;
    endcase
  endfunction

  function automatic void run_tick();
    if (trans_cnt != '0) trans_cnt = trans_cnt - CFG_DATA_W'(1);
    if (!safe_used) safe_cnt = '0;
    safe_used = 1'b0;
    case (st_mode)
      M_START: begin
        if (trans_cnt == '0) begin
          f_init = 1'b1;
          if (!tk.neighbor_link && cfg_primary) st_mode = M_TO_ACTIVE;
          else st_mode = M_PASSIVE;
        end
      end
      M_PASSIVE:    st_mode = passive_next();
      M_TO_ACTIVE:  st_mode = to_active_next();
      M_ACTIVE:     st_mode = active_next();
      M_TO_PASSIVE: st_mode = to_passive_next();
      default: ;
    endcase
  endfunction

  function automatic out_item_t arbitrate(input in_item_t item);
    out_item_t res;
    tk = item;
    case (item.req_type)
      REQ_TICK: begin
        if (enabled) run_tick();
      end
      REQ_ENABLE: begin
        {f_act, f_relay, f_reqdis} = '0;
        st_mode = M_START;
        ta_step = 1'b0;
        tp_step = TP_WAIT_CTRL;
        trans_cnt = cfg_primary ? cfg_start_p : cfg_start_r;
        safe_cnt = '0;
        safe_used = 1'b0;
        enabled = 1'b1;
      end
      REQ_DISABLE: enabled = 1'b0;
      REQ_ORDER_PRIM, REQ_ORDER_RESV, REQ_ORDER_NONE: begin
        order_pending = f_act && ((item.req_type == REQ_ORDER_PRIM && !cfg_primary) ||
                                  (item.req_type == REQ_ORDER_RESV && cfg_primary));
      end
      default: ;
    endcase
    res.is_active = f_act;
    res.relay_drive = f_relay;
    res.request_disable_control = f_reqdis;
    res.init_done = f_init;
    res.mode = st_mode;
    return res;
  endfunction

  function automatic in_item_t uniform_request(input logic [2:0] req, input logic v,
                                               input logic [1:0] health);
    in_item_t it;
    it = '0;
    it[11:2] = {10{v}};
    it.req_type = req;
    it.relay_health = health;
    return it;
  endfunction

  // Link flags drift slowly so timers get to run out; relay health is drawn anew each time.
  function automatic in_item_t random_request();
    in_item_t it;
    int unsigned r;
    for (int i = 2; i < 12; i++) begin
      if ($urandom_range(0, 4) == 0) field_state[i] = ~field_state[i];
    end
    if ($urandom_range(0, 4) != 0) field_state.relay_health = RH_NORMAL;
    else field_state.relay_health = 2'($urandom_range(RH_NOT_ON, RH_SPARE));
    it = field_state;
    r = $urandom_range(0, 99);
    if (r < 84) it.req_type = REQ_TICK;
    else if (r < 86) it.req_type = REQ_ENABLE;
    else if (r < 87) it.req_type = REQ_DISABLE;
    else if (r < 92) it.req_type = REQ_ORDER_PRIM;
    else if (r < 96) it.req_type = REQ_ORDER_RESV;
    else if (r < 98) it.req_type = REQ_ORDER_NONE;
    else if (r < 99) it.req_type = REQ_SPARE_LO;
    else it.req_type = REQ_SPARE_HI;
    return it;
  endfunction

  task automatic send_request(input in_item_t item);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= item;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    predicted_q.push_back(arbitrate(item));
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_request(random_request());
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_registers();
    cfg_idx_e idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = cfg_idx_e'(i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= reg_plan[i];
      @(posedge clk_i);
      case (idx)
        CFG_IS_PRIMARY:     cfg_primary = reg_plan[i][0];
        CFG_START_PRIMARY:  cfg_start_p = reg_plan[i];
        CFG_START_RESERVE:  cfg_start_r = reg_plan[i];
        CFG_RELAY_OPERATE:  cfg_operate = reg_plan[i];
        CFG_RELAY_RELEASE:  cfg_release = reg_plan[i];
        CFG_REMAIN_PASSIVE: cfg_remain = reg_plan[i];
        CFG_SAFE_CHANGE:    cfg_safe = reg_plan[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic plan_small(input logic primary);
    reg_plan[CFG_IS_PRIMARY]     = {15'd0, primary};
    reg_plan[CFG_START_PRIMARY]  = 16'($urandom_range(0, 6));
    reg_plan[CFG_START_RESERVE]  = 16'($urandom_range(0, 6));
    reg_plan[CFG_RELAY_OPERATE]  = 16'($urandom_range(0, 5));
    reg_plan[CFG_RELAY_RELEASE]  = 16'($urandom_range(0, 5));
    reg_plan[CFG_REMAIN_PASSIVE] = 16'($urandom_range(0, 8));
    reg_plan[CFG_SAFE_CHANGE]    = 16'($urandom_range(1, 4));
  endtask

  task automatic plan_uniform(input logic primary, input logic [CFG_DATA_W-1:0] start,
                              input logic [CFG_DATA_W-1:0] rest);
    reg_plan[CFG_IS_PRIMARY] = {15'd0, primary};
    reg_plan[CFG_START_PRIMARY] = start;
    reg_plan[CFG_START_RESERVE] = start;
    for (int i = int'(CFG_RELAY_OPERATE); i < NUM_REGS; i++) reg_plan[i] = rest;
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 51; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 51; end
      default: begin src_idle_pct = 38; snk_stall_pct = 38; end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (predicted_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("result %p arrived with none predicted", got);
    end else begin
      want = predicted_q.pop_front();
      compare_field("is_active", 3'(want.is_active), 3'(got.is_active));
      compare_field("relay_drive", 3'(want.relay_drive), 3'(got.relay_drive));
      compare_field("request_disable_control", 3'(want.request_disable_control),
                    3'(got.request_disable_control));
      compare_field("init_done", 3'(want.init_done), 3'(got.init_done));
      compare_field("mode", want.mode, got.mode);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) check_result(res_if.data);
    res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("redundant_pair_activity_arbiter regression: fail");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    set_idling(0);
    send_request(uniform_request(REQ_TICK, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_ENABLE, 1'b0, RH_NORMAL));
    for (int i = 0; i < 110; i++) begin
      field_state = random_request();
      field_state.req_type = REQ_TICK;
      send_request(field_state);
    end
    send_random(20);
  endtask

  task automatic test_directed_cases();
    in_item_t it;
    settle();
    reg_plan[CFG_IS_PRIMARY]     = 16'd1;
    reg_plan[CFG_START_PRIMARY]  = 16'd2;
    reg_plan[CFG_START_RESERVE]  = 16'd3;
    reg_plan[CFG_RELAY_OPERATE]  = 16'd2;
    reg_plan[CFG_RELAY_RELEASE]  = 16'd2;
    reg_plan[CFG_REMAIN_PASSIVE] = 16'd3;
    reg_plan[CFG_SAFE_CHANGE]    = 16'd2;
    program_registers();
    send_request(uniform_request(REQ_DISABLE, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_ORDER_RESV, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_SPARE_LO, 1'b1, RH_SPARE));
    send_request(uniform_request(REQ_SPARE_HI, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_ENABLE, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b1, RH_SPARE));
    send_request(uniform_request(REQ_ORDER_RESV, 1'b1, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b1, RH_NORMAL));
    it = uniform_request(REQ_TICK, 1'b1, RH_NORMAL);
    it.own_control_active = 1'b0;
    send_request(it);
    send_request(uniform_request(REQ_TICK, 1'b1, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_ORDER_NONE, 1'b1, RH_NORMAL));
    for (int i = 0; i < 3; i++) send_request(uniform_request(REQ_TICK, 1'b0, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b1, RH_NORMAL));
    send_request(uniform_request(REQ_DISABLE, 1'b1, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b1, RH_NORMAL));
    send_request(uniform_request(REQ_ENABLE, 1'b1, RH_NORMAL));
    send_request(uniform_request(REQ_TICK, 1'b1, RH_FAULT));
    send_request(uniform_request(REQ_TICK, 1'b0, RH_NOT_ON));
  endtask

  task automatic test_random_roles();
    for (int phase = 0; phase < 4; phase++) begin
      for (int role = 0; role < 2; role++) begin
        settle();
        plan_small(role[0]);
        program_registers();
        set_idling(phase);
        send_request(uniform_request(REQ_ENABLE, 1'b0, RH_NORMAL));
        send_random(119);
      end
    end
  endtask

  task automatic test_extreme_timers();
    set_idling(3);
    settle();
    plan_uniform(1'b0, '0, '0);
    program_registers();
    send_request(uniform_request(REQ_ENABLE, 1'b0, RH_NORMAL));
    send_random(59);
    settle();
    plan_uniform(1'b1, TIMER_MAX, TIMER_MAX);
    program_registers();
    send_request(uniform_request(REQ_ENABLE, 1'b1, RH_NORMAL));
    send_random(29);
    settle();
    plan_uniform(1'b1, '0, TIMER_MAX);
    program_registers();
    send_request(uniform_request(REQ_ENABLE, 1'b0, RH_NORMAL));
    send_random(59);
  endtask

  task automatic test_drain_pause();
    settle();
    plan_small(1'($urandom_range(0, 1)));
    program_registers();
    set_idling(1);
    send_request(uniform_request(REQ_ENABLE, 1'b0, RH_NORMAL));
    send_random(39);
    settle();
    set_idling(2);
    send_random(40);
  endtask

  initial begin
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_IS_PRIMARY;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    init_model();
    field_state = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_random_roles();
    test_extreme_timers();
    test_drain_pause();
    settle();
    if (mismatches == 0) begin
      $display("redundant_pair_activity_arbiter regression: pass");
    end else begin
      $display("redundant_pair_activity_arbiter regression: fail");
    end
    $finish;
  end

endmodule
